>>> sv/clb_pkg.sv
// ----------------------------------------------------------------------------
// clb_pkg
// shared sizes, opcodes, status codes and chain control for the cursor list
// buffer
// ----------------------------------------------------------------------------
package clb_pkg;

   localparam int CAPACITY  = 64;
   localparam int WORD_BITS = 32;
   localparam int IDX_BITS  = $clog2(CAPACITY);
   localparam int CNT_BITS  = $clog2(CAPACITY + 1);

   // request opcodes
   localparam logic [2:0] OP_START   = 3'd0;
   localparam logic [2:0] OP_ADVANCE = 3'd1;
   localparam logic [2:0] OP_INSERT  = 3'd2;
   localparam logic [2:0] OP_APPEND  = 3'd3;
   localparam logic [2:0] OP_REMOVE  = 3'd4;

   // response status
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   // chain moves, applied to every cell in the same cycle
   localparam logic [2:0] MV_HOLD   = 3'd0;
   localparam logic [2:0] MV_ROTATE = 3'd1;
   localparam logic [2:0] MV_APPEND = 3'd2;
   localparam logic [2:0] MV_PUSH   = 3'd3;
   localparam logic [2:0] MV_POP    = 3'd4;

   typedef struct packed {
      logic [2:0]          move;
      logic [CNT_BITS-1:0] count;
   } chain_ctl_type;

endpackage

>>> sv/clb_cell.sv
// ----------------------------------------------------------------------------
// clb_cell
// one word of the chain; picks its next word from its neighbors, the head
// cell or the incoming word
// ----------------------------------------------------------------------------
module clb_cell (
   input  logic                             clock,
   input  clb_pkg::chain_ctl_type           ctl,
   input  logic [clb_pkg::IDX_BITS-1:0]     idx,
   input  logic [clb_pkg::WORD_BITS-1:0]    left_word,
   input  logic [clb_pkg::WORD_BITS-1:0]    right_word,
   input  logic [clb_pkg::WORD_BITS-1:0]    head_word,
   input  logic [clb_pkg::WORD_BITS-1:0]    new_word,
   output logic [clb_pkg::WORD_BITS-1:0]    word
);

   logic [clb_pkg::WORD_BITS-1:0] word_ff;
   logic [clb_pkg::WORD_BITS-1:0] word_in;
   logic [clb_pkg::CNT_BITS-1:0]  pos;
   logic                          is_first;
   logic                          is_last;
   logic                          is_end;

   assign pos      = clb_pkg::CNT_BITS'(idx);
   assign is_first = (idx == '0);
   assign is_last  = (pos + clb_pkg::CNT_BITS'(1) == ctl.count);
   assign is_end   = (pos == ctl.count);

   always_comb begin
      word_in = word_ff;
      unique case (ctl.move)
         clb_pkg::MV_HOLD: word_in = word_ff;
         // head wraps around to the tail of the held words
         clb_pkg::MV_ROTATE: word_in = is_last ? head_word : right_word;
         clb_pkg::MV_APPEND: begin
            if (is_first) begin
               word_in = new_word;
            end else if (is_end) begin
               word_in = head_word;
            end
         end
         clb_pkg::MV_PUSH: word_in = is_first ? new_word : left_word;
         clb_pkg::MV_POP:  word_in = right_word;
         default:          word_in = word_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

>>> sv/clb_ctrl.sv
// ----------------------------------------------------------------------------
// clb_ctrl
// count, cursor, start rotation counter and response handshake; drives the
// move broadcast to the chain
// ----------------------------------------------------------------------------
module clb_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [2:0]                     req_opcode,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_has_current,
   output logic [6:0]                     rsp_item_count,
   output logic [1:0]                     rsp_status,
   output clb_pkg::chain_ctl_type         ctl
);

   logic [clb_pkg::CNT_BITS-1:0] count_ff, count_in;
   logic [clb_pkg::CNT_BITS-1:0] cursor_ff, cursor_in;
   logic [clb_pkg::CNT_BITS-1:0] steps_ff, steps_in;
   logic                         busy_ff, busy_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [1:0]                   status_ff, status_in;
   logic [2:0]                   move;
   logic                         accept;
   logic                         has_cur;
   logic                         full;

   assign req_stall = busy_ff || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign has_cur   = (cursor_ff < count_ff);
   assign full      = (count_ff >= clb_pkg::CNT_BITS'(clb_pkg::CAPACITY));

   always_comb begin
      count_in     = count_ff;
      cursor_in    = cursor_ff;
      steps_in     = steps_ff;
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      move         = clb_pkg::MV_HOLD;
      priority if (busy_ff) begin
         // bring the first item back to the head, one place per cycle
         move     = clb_pkg::MV_ROTATE;
         steps_in = steps_ff - clb_pkg::CNT_BITS'(1);
         if (steps_ff == clb_pkg::CNT_BITS'(1)) begin
            busy_in      = 1'b0;
            rsp_valid_in = 1'b1;
         end
      end else if (accept) begin
         rsp_valid_in = 1'b1;
         status_in    = clb_pkg::ST_OK;
         unique case (req_opcode)
            clb_pkg::OP_START: begin
               cursor_in = '0;
               if (has_cur && cursor_ff != '0) begin
                  busy_in      = 1'b1;
                  steps_in     = count_ff - cursor_ff;
                  rsp_valid_in = 1'b0;
               end
            end
            clb_pkg::OP_ADVANCE: begin
               if (has_cur) begin
                  move      = clb_pkg::MV_ROTATE;
                  cursor_in = cursor_ff + clb_pkg::CNT_BITS'(1);
               end
            end
            clb_pkg::OP_INSERT: begin
               if (full) begin
                  status_in = clb_pkg::ST_FULL;
               end else begin
                  move      = clb_pkg::MV_PUSH;
                  count_in  = count_ff + clb_pkg::CNT_BITS'(1);
                  cursor_in = has_cur ? cursor_ff : '0;
               end
            end
            clb_pkg::OP_APPEND: begin
               if (full) begin
                  status_in = clb_pkg::ST_FULL;
               end else if (has_cur) begin
                  move      = clb_pkg::MV_APPEND;
                  count_in  = count_ff + clb_pkg::CNT_BITS'(1);
                  cursor_in = cursor_ff + clb_pkg::CNT_BITS'(1);
               end else begin
                  // no current word: new word lands at the end
                  move      = clb_pkg::MV_PUSH;
                  count_in  = count_ff + clb_pkg::CNT_BITS'(1);
                  cursor_in = count_ff;
               end
            end
            clb_pkg::OP_REMOVE: begin
               if (!has_cur) begin
                  status_in = clb_pkg::ST_EMPTY;
               end else begin
                  move     = clb_pkg::MV_POP;
                  count_in = count_ff - clb_pkg::CNT_BITS'(1);
               end
            end
            default: begin
            end
         endcase
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cursor_ff    <= '0;
         steps_ff     <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         status_ff    <= clb_pkg::ST_OK;
      end else begin
         count_ff     <= count_in;
         cursor_ff    <= cursor_in;
         steps_ff     <= steps_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         status_ff    <= status_in;
      end
   end

   assign ctl.move        = move;
   assign ctl.count       = count_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_has_current = has_cur;
   assign rsp_item_count  = 7'(count_ff);
   assign rsp_status      = status_ff;

   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= count_ff)
      else $error("cursor beyond item count");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= clb_pkg::CNT_BITS'(clb_pkg::CAPACITY))
      else $error("item count beyond capacity");

   a_busy_no_rsp: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (!rsp_valid_ff && steps_ff != '0))
      else $error("rotation running with a response pending");

   a_rotate_done: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && steps_ff == clb_pkg::CNT_BITS'(1)) |=> (rsp_valid_ff && !busy_ff))
      else $error("start response missing after rotation");

   a_remove_count: assert property (@(posedge clock) disable iff (reset)
      (accept && req_opcode == clb_pkg::OP_REMOVE && has_cur)
         |=> (count_ff == $past(count_ff) - clb_pkg::CNT_BITS'(1)))
      else $error("remove did not drop the count");

endmodule

>>> sv/cursor_list_buffer.sv
// ----------------------------------------------------------------------------
// cursor_list_buffer
// ordered word list with a cursor, held in a chain of cells that keeps the
// current word at the head
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  req_      in         req_valid/stall    opcode, entry_value
//  rsp_      out        rsp_valid/stall    current_value, has_current,
//                                          item_count, status
//
//  advance, insert, append, remove and a start with the cursor at the head or
//  past the end respond without rotating; a start with the cursor at position r
//  of n held words first rotates the chain by n - r places, one chain rotation per cycle.
//  reset clears count and cursor; cell contents are left as they are.
//  a new request is taken while the previous response is being taken.
//  the response holds steady while rsp_stall is high.
// ----------------------------------------------------------------------------
module cursor_list_buffer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic [31:0] req_entry_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_current_value,
   output logic        rsp_has_current,
   output logic [6:0]  rsp_item_count,
   output logic [1:0]  rsp_status
);

   clb_pkg::chain_ctl_type                                        ctl;
   logic [clb_pkg::CAPACITY-1:0][clb_pkg::WORD_BITS-1:0]          chain_word;
   logic [clb_pkg::WORD_BITS-1:0]                                 new_word;

   assign new_word = req_entry_value[clb_pkg::WORD_BITS-1:0];

   clb_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_has_current (rsp_has_current),
      .rsp_item_count  (rsp_item_count),
      .rsp_status      (rsp_status),
      .ctl             (ctl)
   );

   for (genvar i = 0; i < clb_pkg::CAPACITY; i++) begin : g_cell
      logic [clb_pkg::WORD_BITS-1:0] left_word;
      logic [clb_pkg::WORD_BITS-1:0] right_word;

      if (i == 0) begin : g_first
         assign left_word = '0;
      end else begin : g_inner_l
         assign left_word = chain_word[i-1];
      end

      if (i == clb_pkg::CAPACITY - 1) begin : g_last
         assign right_word = '0;
      end else begin : g_inner_r
         assign right_word = chain_word[i+1];
      end

      clb_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .idx        (clb_pkg::IDX_BITS'(i)),
         .left_word  (left_word),
         .right_word (right_word),
         .head_word  (chain_word[0]),
         .new_word   (new_word),
         .word       (chain_word[i])
      );
   end

   // head cell holds the word under the cursor whenever no start rotation is running
   assign rsp_current_value = rsp_has_current ? 32'(chain_word[0]) : 32'd0;

endmodule
